[rtl/led_wakeup_ramp_sequencer_unit_macros.svh]
// ----------------------------------------------------------------------------
// LED wake-up ramp sequencer assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_WAKEUP_RAMP_SEQUENCER_UNIT_MACROS_SVH
`define LED_WAKEUP_RAMP_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LWRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LWRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LWRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LWRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/lwrs_pkg.sv]
// ----------------------------------------------------------------------------
// LED wake-up ramp sequencer package
// Types, register codes and constants of the ramp sequencer.
// ----------------------------------------------------------------------------
package lwrs_pkg;

   localparam int REQ_W       = 56;
   localparam int RSP_W       = 104;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_AUTO = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RAMP = 2'd1,
      PH_HOLD = 2'd2
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALARM     = 3'd0,
      CSR_RAMP_DUR  = 3'd1,
      CSR_HOLD_TMO  = 3'd2,
      CSR_MV_STEP   = 3'd3,
      CSR_MA_STEP   = 3'd4,
      CSR_START_MV  = 3'd5,
      CSR_TARGET_MV = 3'd6,
      CSR_TARGET_MA = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [10:0] ALARM_RESET    = 11'd315;
   localparam logic [15:0] RAMP_DUR_RESET = 16'd1800;
   localparam logic [15:0] HOLD_TMO_RESET = 16'd65;

   // ramp entry currents, red / green / white
   localparam logic [15:0] RED_START_MA   = 16'd72;
   localparam logic [15:0] GREEN_START_MA = 16'd28;
   localparam logic [15:0] WHITE_START_MA = 16'd44;

   // step periods in seconds; the current period divides the slow one
   localparam logic [3:0] SLOW_PERIOD    = 4'd10;
   localparam logic [3:0] CURRENT_PERIOD = 4'd5;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   // last declared field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [13:0] manual_count;
      logic        manual_count_valid;
      logic [15:0] manual_mv;
      logic        manual_mv_valid;
      logic        white_limit_n;
      logic        red_limit_n;
      logic        second_tick;
      logic [5:0]  clock_minute;
      logic [4:0]  clock_hour;
      logic [2:0]  switch_lines;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] white_ma;
      logic [15:0] green_ma;
      logic [15:0] red_ma;
      logic [15:0] white_mv;
      logic [15:0] green_mv;
      logic [15:0] red_mv;
      logic        power_enable;
      phase_type   auto_phase;
      mode_type    mode;
   } rsp_item_type;

endpackage

[rtl/led_wakeup_ramp_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// LED wake-up ramp sequencer unit
// Mode switch decode, manual setpoints and the timed wake-up ramp of the
// red, green and white LED drivers; one result transaction per poll.
// ----------------------------------------------------------------------------
//
//  channel  direction  width  content
//  req_     in         56     poll transaction (switches, time, tick, limits)
//  rsp_     out        104    mode, phase, power and six setpoints
//  csr_     in         3+48   register write, index and data
//
//  One poll transaction per cycle unless the result is stalled; the path runs
//  through the input register, then the state update and result register.
//  Reset is synchronous, active high, and loads the register reset values.
//  A stalled rsp_tready holds the result; the input register fills and
//  req_tready drops only when both registers are full.
//  csr_ready is always high.
//
`include "led_wakeup_ramp_sequencer_unit_macros.svh"

module led_wakeup_ramp_sequencer_unit
   import lwrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // switch_lines[2:0], clock_hour[7:3], clock_minute[13:8], second_tick[14],
   // red_limit_n[15], white_limit_n[16], manual_mv_valid[17], manual_mv[33:18],
   // manual_count_valid[34], manual_count[48:35], zero pad
   input  logic [REQ_W-1:0]       req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // mode[1:0], auto_phase[3:2], power_enable[4], red_mv[20:5],
   // green_mv[36:21], white_mv[52:37], red_ma[68:53], green_ma[84:69],
   // white_ma[100:85], zero pad
   output logic [RSP_W-1:0]       rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[16] ? SAT16 : s[15:0];
   endfunction

   // configuration registers
   logic [10:0] alarm_ff;
   logic [15:0] ramp_dur_ff;
   logic [15:0] hold_tmo_ff;
   logic [7:0]  mv_step_ff;
   logic [7:0]  ma_step_ff;
   logic [47:0] start_mv_ff;
   logic [47:0] target_mv_ff;
   logic [47:0] target_ma_ff;

   // pipeline
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         advance;

   // sequencer state
   mode_type         mode_ff, mode_in;
   phase_type        phase_ff, phase_in;
   logic             power_ff, power_in;
   logic [15:0]      ramp_sec_ff, ramp_sec_in;
   logic [3:0]       ramp_mod_ff, ramp_mod_in;   // ramp_sec modulo the slow period
   logic [15:0]      hold_sec_ff, hold_sec_in;
   logic             vramp_ff, vramp_in;
   logic             fast_ff, fast_in;
   logic [7:0]       red_cnt_ff, red_cnt_in;
   logic [7:0]       white_cnt_ff, white_cnt_in;
   logic [2:0][15:0] vset_ff, vset_in;
   logic [2:0][15:0] cset_ff, cset_in;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff     <= ALARM_RESET;
         ramp_dur_ff  <= RAMP_DUR_RESET;
         hold_tmo_ff  <= HOLD_TMO_RESET;
         mv_step_ff   <= '0;
         ma_step_ff   <= '0;
         start_mv_ff  <= '0;
         target_mv_ff <= '0;
         target_ma_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALARM:     alarm_ff     <= csr_data[10:0];
            CSR_RAMP_DUR:  ramp_dur_ff  <= csr_data[15:0];
            CSR_HOLD_TMO:  hold_tmo_ff  <= csr_data[15:0];
            CSR_MV_STEP:   mv_step_ff   <= csr_data[7:0];
            CSR_MA_STEP:   ma_step_ff   <= csr_data[7:0];
            CSR_START_MV:  start_mv_ff  <= csr_data;
            CSR_TARGET_MV: target_mv_ff <= csr_data;
            CSR_TARGET_MA: target_ma_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item_type'(req_tdata);
      end
   end

   // next state
   always_comb begin
      logic        sw_auto, sw_off, sw_on;
      mode_type    new_mode;
      logic        phase_chg;
      logic [10:0] minute_of_day;

      mode_in      = mode_ff;
      phase_in     = phase_ff;
      power_in     = power_ff;
      ramp_sec_in  = ramp_sec_ff;
      ramp_mod_in  = ramp_mod_ff;
      hold_sec_in  = hold_sec_ff;
      vramp_in     = vramp_ff;
      fast_in      = fast_ff;
      red_cnt_in   = red_cnt_ff;
      white_cnt_in = white_cnt_ff;
      vset_in      = vset_ff;
      cset_in      = cset_ff;
      phase_chg    = 1'b0;

      sw_auto = in_item_ff.switch_lines[0];
      sw_off  = in_item_ff.switch_lines[1];
      sw_on   = in_item_ff.switch_lines[2];
      minute_of_day = {in_item_ff.clock_hour, 6'd0} - {4'd0, in_item_ff.clock_hour, 2'd0}
                      + {5'd0, in_item_ff.clock_minute};

      // later patterns win
      new_mode = mode_ff;
      if (sw_auto && sw_off) new_mode = MODE_ON;
      if (sw_auto && sw_on)  new_mode = MODE_OFF;
      if (sw_on && sw_off)   new_mode = MODE_AUTO;

      if (new_mode != mode_ff) begin
         mode_in  = new_mode;
         vset_in  = '0;
         cset_in  = '0;
         phase_in = PH_IDLE;
         power_in = (new_mode == MODE_ON);
      end

      unique case (mode_in)
         MODE_ON: begin
            if (in_item_ff.manual_mv_valid) begin
               for (int k = 0; k < 3; k++) vset_in[k] = in_item_ff.manual_mv;
            end
            if (in_item_ff.manual_count_valid) begin
               for (int k = 0; k < 3; k++) cset_in[k] = {in_item_ff.manual_count, 2'b00};
            end
         end
         MODE_AUTO: begin
            unique case (phase_in)
               PH_IDLE: begin
                  if (minute_of_day == alarm_ff) begin
                     phase_in     = PH_RAMP;
                     phase_chg    = 1'b1;
                     power_in     = 1'b1;
                     ramp_sec_in  = '0;
                     ramp_mod_in  = '0;
                     vramp_in     = 1'b1;
                     fast_in      = 1'b0;
                     red_cnt_in   = '0;
                     white_cnt_in = '0;
                     for (int k = 0; k < 3; k++) vset_in[k] = start_mv_ff[16*k +: 16];
                     cset_in[0] = RED_START_MA;
                     cset_in[1] = GREEN_START_MA;
                     cset_in[2] = WHITE_START_MA;
                  end
               end
               PH_RAMP: begin
                  if (ramp_sec_in >= ramp_dur_ff) begin
                     phase_in    = PH_HOLD;
                     phase_chg   = 1'b1;
                     hold_sec_in = '0;
                  end
               end
               PH_HOLD: begin
                  if (hold_sec_in >= hold_tmo_ff) begin
                     phase_in  = PH_IDLE;
                     phase_chg = 1'b1;
                     power_in  = 1'b0;
                     vset_in   = '0;
                     cset_in   = '0;
                  end
               end
               default: ;
            endcase

            if (in_item_ff.second_tick && !phase_chg) begin
               if (phase_in == PH_RAMP) begin
                  // residue freezes once the seconds count saturates
                  if (ramp_sec_in != SAT16) begin
                     ramp_mod_in = (ramp_mod_in == SLOW_PERIOD - 4'd1) ? 4'd0
                                                                       : ramp_mod_in + 4'd1;
                  end
                  ramp_sec_in = sat_add16(ramp_sec_in, 8'd1);
                  if (red_cnt_ff > 8'd3 && white_cnt_ff == 8'd3) begin
                     fast_in = 1'b1;
                  end else begin
                     if (!in_item_ff.red_limit_n && red_cnt_ff != 8'hFF)
                        red_cnt_in = red_cnt_ff + 8'd1;
                     if (!in_item_ff.white_limit_n && white_cnt_ff != 8'hFF)
                        white_cnt_in = white_cnt_ff + 8'd1;
                  end
                  if (vramp_ff) begin
                     if (fast_in || ramp_mod_in == 4'd0) begin
                        for (int k = 0; k < 3; k++) begin
                           if (vset_in[k] < target_mv_ff[16*k +: 16])
                              vset_in[k] = sat_add16(vset_in[k], mv_step_ff);
                           else if (k == 1)
                              vramp_in = 1'b0;
                        end
                     end
                  end else if (ramp_mod_in == 4'd0 || ramp_mod_in == CURRENT_PERIOD) begin
                     for (int k = 0; k < 3; k++) begin
                        if (cset_in[k] < target_ma_ff[16*k +: 16])
                           cset_in[k] = sat_add16(cset_in[k], ma_step_ff);
                     end
                  end
               end else if (phase_in == PH_HOLD) begin
                  hold_sec_in = sat_add16(hold_sec_in, 8'd1);
               end
            end
         end
         default: ;
      endcase
   end

   // result payload and output valid
   always_comb begin
      rsp_item_in              = '0;
      rsp_item_in.mode         = mode_in;
      rsp_item_in.auto_phase   = (mode_in == MODE_AUTO) ? phase_in : PH_IDLE;
      rsp_item_in.power_enable = power_in;
      rsp_item_in.red_mv       = vset_in[0];
      rsp_item_in.green_mv     = vset_in[1];
      rsp_item_in.white_mv     = vset_in[2];
      rsp_item_in.red_ma       = cset_in[0];
      rsp_item_in.green_ma     = cset_in[1];
      rsp_item_in.white_ma     = cset_in[2];

      rsp_valid_in = rsp_valid_ff;
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_OFF;
         phase_ff     <= PH_IDLE;
         power_ff     <= 1'b0;
         ramp_sec_ff  <= '0;
         ramp_mod_ff  <= '0;
         hold_sec_ff  <= '0;
         vramp_ff     <= 1'b1;
         fast_ff      <= 1'b0;
         red_cnt_ff   <= '0;
         white_cnt_ff <= '0;
         vset_ff      <= '0;
         cset_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff      <= mode_in;
            phase_ff     <= phase_in;
            power_ff     <= power_in;
            ramp_sec_ff  <= ramp_sec_in;
            ramp_mod_ff  <= ramp_mod_in;
            hold_sec_ff  <= hold_sec_in;
            vramp_ff     <= vramp_in;
            fast_ff      <= fast_in;
            red_cnt_ff   <= red_cnt_in;
            white_cnt_ff <= white_cnt_in;
            vset_ff      <= vset_in;
            cset_ff      <= cset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   `LWRS_ASSERT_IMP(a_idle_unpowered, clock, reset,
      mode_ff != MODE_ON && phase_ff == PH_IDLE, !power_ff,
      "power enabled outside manual mode while idle")
   `LWRS_ASSERT_IMP(a_phase_only_auto, clock, reset,
      rsp_valid_ff && rsp_item_ff.mode != MODE_AUTO, rsp_item_ff.auto_phase == PH_IDLE,
      "ramp phase reported outside auto mode")
   `LWRS_ASSERT_IMP(a_fast_needs_limits, clock, reset,
      $rose(fast_ff), $past(red_cnt_ff > 8'd3 && white_cnt_ff == 8'd3),
      "fast ramp set without both limit counts qualifying")
   `LWRS_ASSERT_IMP(a_rsp_from_stage, clock, reset,
      $rose(rsp_valid_ff), $past(in_valid_ff),
      "result raised without a staged poll transaction")

endmodule
